### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  localparam int unsigned CELL_W   = 16;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned REM_W    = 3;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [REM_W-1:0]   TAB_STOP    = 3'd4;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_SCROLL,
    ST_DRAIN,
    ST_CLEAR,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
`default_nettype none

// Character-cell text console. Cells are 16 bits: glyph in the low byte,
// attribute in the high byte, held in one single-port-write RAM.
// Input stream: tuser = opcode (0 put, 1 read); tdata = char_code, cell_index.
// Output stream: one item per input item, read_data and the linear cursor.
// cfg channel writes the attribute used for new glyphs and blanks; write it
// only while the console is idle.
// Per item: a read fetches the cell from RAM; a newline or backspace moves
// the cursor; a printable byte writes one cell, a tab writes spaces up to the
// next multiple of four columns. The next item can be taken as soon as the
// result is offered. A newline on the last row or a write to the last cell adds
// a scroll (one RAM read and one write per cell, pipelined); a form feed clears.
// One item is in work at a time; s_axis_tready is high only when idle.
// A finished result waits in the output register, so a new item is accepted
// while the receiver stalls; the next result waits until that one is taken.
// After reset a clearing pass fills every cell with a light grey space; no
// item is accepted during it, cfg writes are taken.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero
  input  wire         s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data[15:0], cursor_index[26:16], zero
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [tcw_pkg::COLOR_W-1:0] cfg_data_i
);

  import tcw_pkg::*;

  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned CMP_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W:0]   CELLS_X   = (ADDR_W+1)'(CELLS);
  localparam logic [ADDR_W:0]   COLS_X    = (ADDR_W+1)'(COLUMNS);

  state_e              state_q, state_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic [ADDR_W-1:0]   dst_q, dst_d;
  logic                wr_pend_q, wr_pend_d;
  logic [ADDR_W-1:0]   wr_dst_q, wr_dst_d;
  logic                wr_blank_q, wr_blank_d;
  logic [CELL_W-1:0]   data_q, data_d;
  logic                m_valid_q, m_valid_d;
  logic [31:0]         m_data_q, m_data_d;
  logic [COLOR_W-1:0]  color_q;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic                in_accept;
  logic [CHAR_W-1:0]   in_char;
  logic [INDEX_W-1:0]  in_index;
  logic                in_range;
  logic [ADDR_W-1:0]   cur_lin;
  logic [ADDR_W:0]     src_x;
  logic [CELL_W-1:0]   blank_cell;

  assign in_char    = s_axis_tdata[7:0];
  assign in_index   = s_axis_tdata[18:8];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_range   = CMP_W'(in_index) < CMP_W'(CELLS);
  assign cur_lin    = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
  assign src_x      = {1'b0, dst_q} + COLS_X;
  assign blank_cell = {color_q, BLANK_CHAR};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      row_q     <= '0;
      col_q     <= '0;
      dst_q     <= '0;
      wr_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
      color_q   <= RESET_COLOR;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      dst_q     <= dst_d;
      wr_pend_q <= wr_pend_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    char_q     <= char_d;
    wr_dst_q   <= wr_dst_d;
    wr_blank_q <= wr_blank_d;
    data_q     <= data_d;
    m_data_q   <= m_data_d;
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    rem_d      = rem_q;
    char_d     = char_q;
    dst_d      = dst_q;
    wr_pend_d  = 1'b0;
    wr_dst_d   = wr_dst_q;
    wr_blank_d = wr_blank_q;
    data_d     = data_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = blank_cell;

    // finish the shifted-row write issued last cycle
    if (wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_dst_q;
      ram_wdata = wr_blank_q ? blank_cell : ram_rdata;
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = dst_q;
        ram_wdata = {RESET_COLOR, BLANK_CHAR};
        if (dst_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end else begin
          dst_d = dst_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          data_d = '0;
          if (s_axis_tuser == OP_READ) begin
            if (in_range) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(in_index);
              state_d   = ST_READ;
            end else begin
              state_d = ST_FINISH;
            end
          end else begin
            unique case (in_char)
              CH_NL: begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  rem_d   = '0;
                  dst_d   = '0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d   = row_q + ROW_W'(1);
                  state_d = ST_FINISH;
                end
              end
              CH_FF: begin
                row_d   = '0;
                col_d   = '0;
                dst_d   = '0;
                state_d = ST_CLEAR;
              end
              CH_TAB: begin
                rem_d   = TAB_STOP - {1'b0, col_q[1:0]};
                char_d  = BLANK_CHAR;
                state_d = ST_PUT;
              end
              CH_BS: begin
                if (col_q != '0) begin
                  col_d = col_q - COL_W'(1);
                end else if (row_q != '0) begin
                  row_d = row_q - ROW_W'(1);
                  col_d = LAST_COL;
                end
                state_d = ST_FINISH;
              end
              default: begin
                rem_d   = REM_W'(1);
                char_d  = in_char;
                state_d = ST_PUT;
              end
            endcase
          end
        end
      end

      ST_READ: begin
        data_d  = ram_rdata;
        state_d = ST_FINISH;
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_lin;
        ram_wdata = {color_q, char_q};
        rem_d     = rem_q - REM_W'(1);
        state_d   = (rem_q == REM_W'(1)) ? ST_FINISH : ST_PUT;
        if (col_q == LAST_COL) begin
          col_d = '0;
          if (row_q == LAST_ROW) begin
            dst_d   = '0;
            state_d = ST_SCROLL;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end

      ST_SCROLL: begin
        // read the cell one row below, write it up one row next cycle
        if (src_x < CELLS_X) begin
          ram_re    = 1'b1;
          ram_raddr = src_x[ADDR_W-1:0];
        end
        wr_pend_d  = 1'b1;
        wr_dst_d   = dst_q;
        wr_blank_d = (src_x >= CELLS_X);
        if (dst_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end else begin
          dst_d = dst_q + ADDR_W'(1);
        end
      end

      ST_DRAIN: begin
        state_d = (rem_q != '0) ? ST_PUT : ST_FINISH;
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_q;
        ram_wdata = blank_cell;
        if (dst_q == LAST_CELL) begin
          state_d = ST_FINISH;
        end else begin
          dst_d = dst_q + ADDR_W'(1);
        end
      end

      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, INDEX_W'(cur_lin), data_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // the scroll write-back never collides with a glyph write
  a_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == ST_SCROLL || state_q == ST_DRAIN))
    else $error("pending scroll write outside scroll");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ROW_W+1)'(row_q) < (ROW_W+1)'(ROWS) && (COL_W+1)'(col_q) < (COL_W+1)'(COLUMNS))
    else $error("cursor out of screen");

endmodule

`default_nettype wire
